// ===== hw/rtl/mpqa_pkg.sv =====
package mpqa_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 4;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] item_data;
        logic signed [31:0] item_priority;
    } request_t;

    typedef struct packed {
        logic        [1:0]           status;
        logic signed [31:0]          removed_data;
        logic                        front_valid;
        logic signed [31:0]          front_data;
        logic signed [31:0]          front_priority;
        logic        [OUT_CNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } entry_t;

    // Controls for the running-minimum tracker.
    typedef struct packed {
        logic             clear;
        logic             take;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } track_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } front_t;

endpackage

// ===== hw/rtl/mpqa_min_track.sv =====
module mpqa_min_track (
    input  logic                clk,
    input  logic                rst_n,
    input  mpqa_pkg::track_ctl_t ctl,
    output mpqa_pkg::front_t    front
);
    import mpqa_pkg::*;

    logic             valid_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           entry_reg;
    logic             replace;

    // Strictly smaller wins, so among equal priorities the earliest candidate stays.
    assign replace = ctl.take && (!valid_reg || (ctl.entry.prio < entry_reg.prio));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (replace)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && replace)
        begin
            idx_reg   <= ctl.idx;
            entry_reg <= ctl.entry;
        end
    end

    assign front.valid = valid_reg;
    assign front.idx   = idx_reg;
    assign front.entry = entry_reg;

endmodule

// ===== hw/rtl/min_priority_queue_array_unit.sv =====
// Array priority queue with linear-scan minimum and order-preserving removal.
//
// A command is transferred on a rising edge with start high and busy low; request
// carries the action (insert, delete minimum, anything else is a peek), the data
// and the priority. Exactly one result follows per command: done is high for one
// cycle and result holds the status, the removed data, the current minimum entry
// and the entry count. The receiver cannot stall; the result is taken that cycle.
//
// Insert, peek, overflow and underflow: done in the cycle after the transfer, busy
// stays low, so these commands can be issued every cycle.
// Delete: the held entries are read from the entry memory once each (one read
// port), shifted down behind the removed one and rescanned for the new minimum.
// While the delete runs, busy is high; done follows once the last held entry has
// been read and written back into place.
// The minimum entry is kept in a register so inserts and peeks need no scan.
//
// Reset empties the queue at once; the memory contents are not cleared.
module min_priority_queue_array_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mpqa_pkg::request_t  request,
    output logic                done,
    output mpqa_pkg::result_t   result
);
    import mpqa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic             state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] old_cnt_reg, old_cnt_next;
    logic [CNT_W-1:0] iss_reg,     iss_next;
    logic             rdv_reg,     rdv_next;
    logic [IDX_W-1:0] rj_reg,      rj_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next;
    logic             done_reg,    done_next;
    logic [1:0]       status_reg,  status_next;
    logic [31:0]      removed_reg, removed_next;

    entry_t           mem [CAPACITY];
    entry_t           rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             accept;
    logic             full;
    logic             keep;
    logic             after;
    logic [IDX_W-1:0] new_pos;
    track_ctl_t       track_ctl;
    front_t           front;

    assign accept  = start && (state_reg == S_IDLE);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign keep    = rdv_reg && (rj_reg != min_idx_reg);
    assign after   = rdv_reg && (rj_reg > min_idx_reg);
    assign new_pos = after ? (rj_reg - IDX_W'(1)) : rj_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        old_cnt_next = old_cnt_reg;
        iss_next     = iss_reg;
        rdv_next     = 1'b0;
        rj_next      = rj_reg;
        min_idx_next = min_idx_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        removed_next = removed_reg;
        wr_en        = 1'b0;
        wr_addr      = new_pos;
        wr_data      = rd_data_reg;
        track_ctl    = '{clear: 1'b0, take: keep, idx: new_pos, entry: rd_data_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = STATUS_OK;
                    removed_next = '0;
                    if (request.action == ACT_INSERT)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            status_next = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            wr_data         = '{data: request.item_data,
                                                prio: request.item_priority};
                            track_ctl.take  = 1'b1;
                            track_ctl.idx   = count_reg[IDX_W-1:0];
                            track_ctl.entry = wr_data;
                            count_next      = count_reg + CNT_W'(1);
                        end
                    end
                    else if (request.action == ACT_DELETE)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_UNDERFLOW;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            removed_next    = front.entry.data;
                            min_idx_next    = front.idx;
                            old_cnt_next    = count_reg;
                            count_next      = count_reg - CNT_W'(1);
                            iss_next        = '0;
                            track_ctl.clear = 1'b1;
                            state_next      = S_SCAN;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // Reads run ahead of writes: an entry moves down into a slot
                // that has already been read.
                if (iss_reg < old_cnt_reg)
                begin
                    rdv_next = 1'b1;
                    rj_next  = iss_reg[IDX_W-1:0];
                    iss_next = iss_reg + CNT_W'(1);
                end
                wr_en = after;
                if (rdv_reg && (CNT_W'(rj_reg) == old_cnt_reg - CNT_W'(1)))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_cnt_reg <= old_cnt_next;
        iss_reg     <= iss_next;
        rj_reg      <= rj_next;
        min_idx_reg <= min_idx_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
    end

    mpqa_min_track u_min_track (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (track_ctl),
        .front (front)
    );

    assign busy = (state_reg == S_SCAN);
    assign done = done_reg;

    assign result.status         = status_reg;
    assign result.removed_data   = removed_reg;
    assign result.front_valid    = front.valid;
    assign result.front_data     = front.valid ? front.entry.data : '0;
    assign result.front_priority = front.valid ? front.entry.prio : '0;
    assign result.entry_count    = OUT_CNT_W'(count_reg);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a delete is still in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_front_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (front.valid == (count_reg != '0)))
        else $error("front valid disagrees with entry count");

    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.action != ACT_DELETE)) |=> done)
        else $error("non-delete command did not complete in one cycle");

endmodule

// ===== tb/tb_min_priority_queue_array_unit.sv =====
module tb_min_priority_queue_array_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mpqa_pkg::*;

    // Action codes the package leaves unnamed: both behave as a peek.
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    // Mirror of the queue contents plus the results still owed by the block.
    class min_queue_tracker;
        logic signed [31:0] held_data [CAPACITY];
        logic signed [31:0] held_prio [CAPACITY];
        int unsigned        held;
        result_t            owed_results [$];
        int unsigned        errors;
        int unsigned        n_insert, n_delete, n_peek, n_overflow, n_underflow;

        function new();
            held = 0;
            errors = 0;
            n_insert = 0;
            n_delete = 0;
            n_peek = 0;
            n_overflow = 0;
            n_underflow = 0;
        endfunction

        // Earliest held entry with the smallest priority.
        function int unsigned min_slot();
            int unsigned best;
            best = 0;
            for (int unsigned k = 1; k < held; k++)
                if (held_prio[k] < held_prio[best])
                    best = k;
            return best;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void note_command(request_t cmd);
            result_t     res;
            int unsigned m;
            res = '0;
            res.status = STATUS_OK;
            if (cmd.action == ACT_INSERT) begin
                n_insert++;
                if (held >= CAPACITY) begin
                    res.status = STATUS_OVERFLOW;
                    n_overflow++;
                end
                else begin
                    held_data[held] = cmd.item_data;
                    held_prio[held] = cmd.item_priority;
                    held++;
                end
            end
            else if (cmd.action == ACT_DELETE) begin
                n_delete++;
                if (held == 0) begin
                    res.status = STATUS_UNDERFLOW;
                    n_underflow++;
                end
                else begin
                    m = min_slot();
                    res.removed_data = held_data[m];
                    for (int unsigned k = m; k + 1 < held; k++) begin
                        held_data[k] = held_data[k + 1];
                        held_prio[k] = held_prio[k + 1];
                    end
                    held--;
                end
            end
            else begin
                n_peek++;
            end
            if (held > 0) begin
                m = min_slot();
                res.front_valid    = 1'b1;
                res.front_data     = held_data[m];
                res.front_priority = held_prio[m];
            end
            res.entry_count = held[OUT_CNT_W-1:0];
            owed_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (owed_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            exp = owed_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.removed_data !== exp.removed_data) begin
                $error("removed_data: expected %0d, got %0d", exp.removed_data,
                       got.removed_data);
                errors++;
            end
            if (got.front_valid !== exp.front_valid) begin
                $error("front_valid: expected %0d, got %0d", exp.front_valid,
                       got.front_valid);
                errors++;
            end
            if (got.front_data !== exp.front_data) begin
                $error("front_data: expected %0d, got %0d", exp.front_data,
                       got.front_data);
                errors++;
            end
            if (got.front_priority !== exp.front_priority) begin
                $error("front_priority: expected %0d, got %0d", exp.front_priority,
                       got.front_priority);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    request_t request = '0;
    logic     done;
    result_t  result;

    min_queue_tracker queue_model = new();

    min_priority_queue_array_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            queue_model.check_result(result);
    end

    // Holds start high until the block takes the command, then records it.
    task automatic transfer_command(input request_t cmd);
        start   <= 1'b1;
        request <= cmd;
        do
            @(posedge clk);
        while (busy);
        queue_model.note_command(cmd);
    endtask

    task automatic sender_pause(input int unsigned cycles);
        start   <= 1'b0;
        request <= '{action: 2'($urandom), item_data: $signed($urandom),
                     item_priority: $signed($urandom)};
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending until every outstanding result has been transferred.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (queue_model.pending() > 0)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [1:0] act, input logic signed [31:0] data,
                               input logic signed [31:0] prio);
        request_t cmd;
        cmd.action        = act;
        cmd.item_data     = data;
        cmd.item_priority = prio;
        transfer_command(cmd);
    endtask

    function automatic logic [1:0] pick_action(input int unsigned insert_weight);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < insert_weight)
            return ACT_INSERT;
        else if (r < 90)
            return ACT_DELETE;
        else if (r < 96)
            return ACT_PEEK;
        else
            return ACT_SPARE;
    endfunction

    // Narrow priorities give plenty of ties; the rest cover the full signed range.
    function automatic logic signed [31:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 6)) - 32'sd3;
            1: begin
                case ($urandom_range(0, 3))
                    0: return INT_MIN;
                    1: return INT_MAX;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned burst_left;
        int unsigned insert_weight;
        int unsigned w;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: peek, the spare code and an underflowing delete.
        send_fields(ACT_PEEK, 32'sd11, 32'sd22);
        send_fields(ACT_SPARE, INT_MIN, INT_MAX);
        send_fields(ACT_DELETE, 32'sd0, 32'sd0);
        // Fill with extremes and ties on both ends of the priority range.
        send_fields(ACT_INSERT, INT_MIN, INT_MAX);
        send_fields(ACT_INSERT, INT_MAX, INT_MIN);
        send_fields(ACT_INSERT, 32'sd1, 32'sd0);
        send_fields(ACT_INSERT, 32'sd2, 32'sd0);
        send_fields(ACT_INSERT, 32'sd3, -32'sd1);
        send_fields(ACT_INSERT, 32'sd4, INT_MIN);
        send_fields(ACT_INSERT, -32'sd1, -32'sd1);
        send_fields(ACT_INSERT, 32'sd0, INT_MAX);
        send_fields(ACT_INSERT, 32'sd5, INT_MIN);
        send_fields(ACT_PEEK, 32'sd0, 32'sd0);
        send_fields(ACT_SPARE, -32'sd1, -32'sd1);
        // Drain completely; ties must come out in insertion order.
        repeat (CAPACITY) send_fields(ACT_DELETE, $signed($urandom), $signed($urandom));
        send_fields(ACT_DELETE, 32'sd0, 32'sd0);
        drain_results();

        burst_left    = $urandom_range(1, 40);
        insert_weight = 50;
        for (int i = 0; i < 1000; i++) begin
            // Every 125 commands, pick a fill-heavy, balanced or drain-heavy phase at random.
            if (i % 125 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_weight = 15;
                    1: insert_weight = 50;
                    default: insert_weight = 85;
                endcase
            end
            if (i == 500)
                drain_results();
            send_fields(pick_action(insert_weight), $signed($urandom), pick_priority());
            burst_left--;
            if (burst_left == 0) begin
                sender_pause($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        w = 0;
        while (w < 1000 && queue_model.pending() > 0) begin
            @(posedge clk);
            w++;
        end
        repeat (20) @(posedge clk);
        if (queue_model.pending() > 0) begin
            $error("%0d results never arrived", queue_model.pending());
            queue_model.errors++;
        end

        $display("Commands sent: %0d inserts, %0d deletes, %0d peeks",
                 queue_model.n_insert, queue_model.n_delete, queue_model.n_peek);
        $display("Full-queue inserts rejected: %0d, empty-queue deletes: %0d",
                 queue_model.n_overflow, queue_model.n_underflow);
        if (queue_model.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
